### rtl/bsc_pkg.sv
package bsc_pkg;

  localparam int STEP_COUNT_BITS_DEF = 16;
  localparam int CFG_DATA_BITS       = 16;
  localparam int CFG_INDEX_BITS      = 3;
  localparam int HOURS_PER_DAY       = 24;
  localparam int MINUTES_PER_HOUR    = 60;

  // register indexes of the configuration port
  localparam logic [CFG_INDEX_BITS-1:0] CFG_LIGHT_LIMIT  = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_OPEN_HR      = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_OPEN_MINUTE  = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CLOSE_HR     = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CLOSE_MINUTE = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_OPEN_TRAVEL  = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CLOSE_TRAVEL = 3'd6;

  localparam logic [9:0]  RST_LIGHT_LIMIT  = 10'd400;
  localparam logic [4:0]  RST_OPEN_HR      = 5'd7;
  localparam logic [5:0]  RST_OPEN_MINUTE  = 6'd0;
  localparam logic [4:0]  RST_CLOSE_HR     = 5'd20;
  localparam logic [5:0]  RST_CLOSE_MINUTE = 6'd0;
  localparam logic [15:0] RST_OPEN_TRAVEL  = 16'd3000;
  localparam logic [15:0] RST_CLOSE_TRAVEL = 16'd3000;
  localparam logic [4:0]  RST_HOUR         = 5'd7;
  localparam logic [5:0]  RST_MINUTE       = 6'd0;

  localparam logic [3:0] SW_ALL_RELEASED = 4'hF;

  typedef enum logic [1:0] {
    MODE_LIGHT  = 2'd0,
    MODE_SCHED  = 2'd1,
    MODE_MANUAL = 2'd2,
    MODE_PICK   = 2'd3
  } mode_t;

  typedef struct packed {
    logic [9:0] light_level;
    logic [3:0] switches;
    logic       minute_pulse;
  } in_word_t;

  typedef struct packed {
    logic [3:0] coil_pattern;
    logic       blind_is_open;
    logic       moving;
    logic [1:0] mode;
    logic [4:0] hour;
    logic [5:0] minute;
  } out_word_t;

  typedef struct packed {
    logic [9:0]  light_limit;
    logic [4:0]  open_hr;
    logic [5:0]  open_minute;
    logic [4:0]  close_hr;
    logic [5:0]  close_minute;
    logic [15:0] open_travel;
    logic [15:0] close_travel;
  } cfg_regs_t;

  // half-step coil sequence
  function automatic logic [3:0] half_step(input logic [2:0] ph);
    logic [3:0] pat;
    unique case (ph)
      3'd0: pat = 4'b1000;
      3'd1: pat = 4'b1100;
      3'd2: pat = 4'b0100;
      3'd3: pat = 4'b0110;
      3'd4: pat = 4'b0010;
      3'd5: pat = 4'b0011;
      3'd6: pat = 4'b0001;
      default: pat = 4'b1001;
    endcase
    return pat;
  endfunction

endpackage

### rtl/bsc_cfg.sv
module bsc_cfg import bsc_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_wdata,
  output cfg_regs_t                 cfg
);

  cfg_regs_t cfg_r;
  cfg_regs_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_LIGHT_LIMIT:  cfg_nxt.light_limit  = cfg_wdata[9:0];
        CFG_OPEN_HR:      cfg_nxt.open_hr      = cfg_wdata[4:0];
        CFG_OPEN_MINUTE:  cfg_nxt.open_minute  = cfg_wdata[5:0];
        CFG_CLOSE_HR:     cfg_nxt.close_hr     = cfg_wdata[4:0];
        CFG_CLOSE_MINUTE: cfg_nxt.close_minute = cfg_wdata[5:0];
        CFG_OPEN_TRAVEL:  cfg_nxt.open_travel  = cfg_wdata;
        CFG_CLOSE_TRAVEL: cfg_nxt.close_travel = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.light_limit  <= RST_LIGHT_LIMIT;
      cfg_r.open_hr      <= RST_OPEN_HR;
      cfg_r.open_minute  <= RST_OPEN_MINUTE;
      cfg_r.close_hr     <= RST_CLOSE_HR;
      cfg_r.close_minute <= RST_CLOSE_MINUTE;
      cfg_r.open_travel  <= RST_OPEN_TRAVEL;
      cfg_r.close_travel <= RST_CLOSE_TRAVEL;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### rtl/bsc_core.sv
module bsc_core import bsc_pkg::*; #(
  parameter int STEP_COUNT_BITS = STEP_COUNT_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step_en,
  input  in_word_t  word,
  input  cfg_regs_t cfg,
  output out_word_t res_nxt
);

  localparam int TW = (STEP_COUNT_BITS > 16) ? STEP_COUNT_BITS : 16;
  localparam logic [TW-1:0] STEP_MAX_EXT = TW'({STEP_COUNT_BITS{1'b1}});

  logic                       open_r, open_nxt;
  mode_t                      mode_r, mode_nxt;
  logic                       latched_r, latched_nxt;
  logic [2:0]                 phase_r, phase_nxt;
  logic [STEP_COUNT_BITS-1:0] steps_r, steps_nxt;
  logic                       dir_r, dir_nxt;
  logic [3:0]                 coils_r, coils_nxt;
  logic [4:0]                 hour_r, hour_nxt;
  logic [5:0]                 minute_r, minute_nxt;

  logic                       go;
  logic                       go_dir;
  logic                       above;
  logic                       at_open;
  logic                       at_close;
  logic [TW-1:0]              travel_ext;
  logic [STEP_COUNT_BITS-1:0] travel_sat;

  always_comb begin
    open_nxt    = open_r;
    mode_nxt    = mode_r;
    latched_nxt = latched_r;
    phase_nxt   = phase_r;
    steps_nxt   = steps_r;
    dir_nxt     = dir_r;
    coils_nxt   = coils_r;
    hour_nxt    = hour_r;
    minute_nxt  = minute_r;
    go          = 1'b0;
    go_dir      = 1'b0;

    // mode latch, lowest pressed switch wins
    if (!latched_r) begin
      latched_nxt = 1'b1;
      priority if (!word.switches[0]) mode_nxt = MODE_LIGHT;
      else if (!word.switches[1])     mode_nxt = MODE_SCHED;
      else if (!word.switches[2])     mode_nxt = MODE_MANUAL;
      else if (!word.switches[3])     mode_nxt = MODE_PICK;
      else                            latched_nxt = 1'b0;
    end else if (word.switches == SW_ALL_RELEASED) begin
      latched_nxt = 1'b0;
    end

    above    = word.light_level > cfg.light_limit;
    at_open  = (hour_r == cfg.open_hr) && (minute_r == cfg.open_minute);
    at_close = (hour_r == cfg.close_hr) && (minute_r == cfg.close_minute);

    if (word.minute_pulse) begin
      if (steps_r == '0) begin
        unique case (mode_nxt)
          MODE_LIGHT: begin
            if (above && !open_r) begin
              go = 1'b1; go_dir = 1'b1;
            end else if (!above && open_r) begin
              go = 1'b1; go_dir = 1'b0;
            end
          end
          MODE_SCHED: begin
            if (at_open && !open_r) begin
              go = 1'b1; go_dir = 1'b1;
            end else if (at_close && open_r) begin
              go = 1'b1; go_dir = 1'b0;
            end
          end
          default: ;
        endcase
      end
      if (minute_r == 6'(MINUTES_PER_HOUR - 1)) begin
        minute_nxt = '0;
        hour_nxt   = (hour_r == 5'(HOURS_PER_DAY - 1)) ? '0 : hour_r + 5'd1;
      end else begin
        minute_nxt = minute_r + 6'd1;
      end
    end

    travel_ext = TW'(go_dir ? cfg.open_travel : cfg.close_travel);
    travel_sat = (travel_ext > STEP_MAX_EXT) ? STEP_MAX_EXT[STEP_COUNT_BITS-1:0]
                                             : travel_ext[STEP_COUNT_BITS-1:0];

    if (go) begin
      if (travel_sat == '0) begin
        open_nxt = go_dir;
      end else begin
        dir_nxt   = go_dir;
        steps_nxt = travel_sat;
      end
    end

    // one half step per tick, first step in the starting tick
    if (steps_nxt != '0) begin
      phase_nxt = dir_nxt ? phase_r + 3'd1 : phase_r - 3'd1;
      coils_nxt = half_step(phase_nxt);
      steps_nxt = steps_nxt - STEP_COUNT_BITS'(1);
      if (steps_nxt == '0) open_nxt = dir_nxt;
    end

    res_nxt.coil_pattern  = coils_nxt;
    res_nxt.blind_is_open = open_nxt;
    res_nxt.moving        = steps_nxt != '0;
    res_nxt.mode          = mode_nxt;
    res_nxt.hour          = hour_nxt;
    res_nxt.minute        = minute_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r    <= 1'b0;
      mode_r    <= MODE_PICK;
      latched_r <= 1'b0;
      phase_r   <= '0;
      steps_r   <= '0;
      dir_r     <= 1'b0;
      coils_r   <= '0;
      hour_r    <= RST_HOUR;
      minute_r  <= RST_MINUTE;
    end else if (step_en) begin
      open_r    <= open_nxt;
      mode_r    <= mode_nxt;
      latched_r <= latched_nxt;
      phase_r   <= phase_nxt;
      steps_r   <= steps_nxt;
      dir_r     <= dir_nxt;
      coils_r   <= coils_nxt;
      hour_r    <= hour_nxt;
      minute_r  <= minute_nxt;
    end
  end

endmodule

### rtl/blind_stepper_controller.sv
// Blind stepper controller: each input word is one step-period tick carrying a light
// sample, four active-low switches and a minute pulse, and each tick returns one
// result word with the coil pattern, blind state, moving flag, mode and clock after
// that tick. One word is taken per clock while the output side keeps taking results;
// a word waits in the input register while the single-pass tick update runs, and its
// result is registered in the output register. Configuration registers are to be
// written through the cfg_ port only while the block is idle; the user is bound by
// this and the block does not enforce it. No clearing pass is needed after reset.
module blind_stepper_controller import bsc_pkg::*; #(
  parameter int STEP_COUNT_BITS = STEP_COUNT_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  in_word_t                  in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output out_word_t                 out_data,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_wdata
);

  logic      stage_vld_r, stage_vld_nxt;
  in_word_t  stage_word_r;
  logic      out_vld_r, out_vld_nxt;
  out_word_t out_word_r;
  logic      adv;
  logic      in_fire;
  cfg_regs_t cfg;
  out_word_t res_nxt;

  // tick runs when a word is staged and the output register is free or being emptied
  assign adv      = stage_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !stage_vld_r || adv;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    stage_vld_nxt = in_fire ? 1'b1 : (adv ? 1'b0 : stage_vld_r);
    out_vld_nxt   = adv ? 1'b1 : (out_ready ? 1'b0 : out_vld_r);
  end

  bsc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bsc_core #(
    .STEP_COUNT_BITS (STEP_COUNT_BITS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (adv),
    .word    (stage_word_r),
    .cfg     (cfg),
    .res_nxt (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_vld_r <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      stage_vld_r <= stage_vld_nxt;
      out_vld_r   <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) stage_word_r <= in_data;
    if (adv)     out_word_r   <= res_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_word_r;

endmodule

### dv/tb_blind_stepper_controller.sv
module tb_blind_stepper_controller;
  import bsc_pkg::*;

  localparam int SEGMENTS      = 20;
  localparam int SEGMENT_TICKS = 100;
  localparam int QUIET_LIMIT   = 2000;
  localparam int TUNED_FROM    = 8;
  localparam int OPENING_ROWS  = 18;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_INDEX = 3'd7;
  // half-step sequence, entry 0 in the low nibble
  localparam logic [31:0] COIL_SEQ = {4'h9, 4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8};

  typedef struct packed {
    in_word_t  w;
    logic      typed;
    out_word_t want;
  } tick_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_word_t in_data;
  logic out_valid;
  logic out_ready;
  out_word_t out_data;
  logic cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_wdata;

  blind_stepper_controller dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // shadow of the controller
  cfg_regs_t   regs_now;
  logic        blind_open;
  mode_t       cur_mode;
  logic        mode_held;
  logic [2:0]  coil_phase;
  logic [15:0] steps_to_go;
  logic        move_up;
  logic [3:0]  coil_bits;
  logic [4:0]  clk_hour;
  logic [5:0]  clk_minute;

  out_word_t status_due [$];
  tick_row_t opening_rows [OPENING_ROWS];

  int mismatches = 0;
  int quiet_cycles = 0;
  int send_gap_pct = 0;
  int take_stall_pct = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic begin_travel(input logic dir, input logic [15:0] travel);
    if (travel == 16'd0) begin
      blind_open = dir;
    end else begin
      move_up = dir;
      steps_to_go = travel;
    end
  endtask

  task automatic advance_blind(input in_word_t w, output out_word_t r);
    logic at_open;
    logic at_close;
    if (!mode_held) begin
      // the loop stops at the lowest pressed switch
      for (int i = 0; i < 4 && !mode_held; i++) begin
        if (!w.switches[i]) begin
          cur_mode = mode_t'(i[1:0]);
          mode_held = 1'b1;
        end
      end
    end else if (w.switches == SW_ALL_RELEASED) begin
      mode_held = 1'b0;
    end
    if (w.minute_pulse) begin
      if (steps_to_go == 16'd0) begin
        case (cur_mode)
          MODE_LIGHT: begin
            if (w.light_level > regs_now.light_limit && !blind_open)
              begin_travel(1'b1, regs_now.open_travel);
            else if (w.light_level <= regs_now.light_limit && blind_open)
              begin_travel(1'b0, regs_now.close_travel);
          end
          MODE_SCHED: begin
            at_open = clk_hour == regs_now.open_hr && clk_minute == regs_now.open_minute;
            at_close = clk_hour == regs_now.close_hr && clk_minute == regs_now.close_minute;
            if (at_open && !blind_open)
              begin_travel(1'b1, regs_now.open_travel);
            else if (at_close && blind_open)
              begin_travel(1'b0, regs_now.close_travel);
          end
          default: ;
        endcase
      end
      if (clk_minute == 6'(MINUTES_PER_HOUR - 1)) begin
        clk_minute = 6'd0;
        clk_hour = (clk_hour == 5'(HOURS_PER_DAY - 1)) ? 5'd0 : clk_hour + 5'd1;
      end else begin
        clk_minute = clk_minute + 6'd1;
      end
    end
    if (steps_to_go != 16'd0) begin
      coil_phase = move_up ? coil_phase + 3'd1 : coil_phase - 3'd1;
      coil_bits = COIL_SEQ[coil_phase*4 +: 4];
      steps_to_go = steps_to_go - 16'd1;
      if (steps_to_go == 16'd0) blind_open = move_up;
    end
    r.coil_pattern = coil_bits;
    r.blind_is_open = blind_open;
    r.moving = steps_to_go != 16'd0;
    r.mode = cur_mode;
    r.hour = clk_hour;
    r.minute = clk_minute;
  endtask

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_word(input in_word_t w, input logic typed, input out_word_t want);
    out_word_t r;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    advance_blind(w, r);
    status_due.push_back(typed ? want : r);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (status_due.size() != 0) @(negedge clk);
  endtask

  task automatic put_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [15:0] val,
                         input int width);
    logic [15:0] keep;
    keep = 16'((32'd1 << width) - 1);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    // bits above the register width are junk and must be dropped
    cfg_wdata <= (val & keep) | (16'($urandom) & ~keep);
    @(negedge clk);
  endtask

  task automatic load_config(input cfg_regs_t c);
    put_reg(CFG_SPARE_INDEX, 16'($urandom), 0);
    put_reg(CFG_LIGHT_LIMIT, 16'(c.light_limit), 10);
    put_reg(CFG_OPEN_HR, 16'(c.open_hr), 5);
    put_reg(CFG_OPEN_MINUTE, 16'(c.open_minute), 6);
    put_reg(CFG_CLOSE_HR, 16'(c.close_hr), 5);
    put_reg(CFG_CLOSE_MINUTE, 16'(c.close_minute), 6);
    put_reg(CFG_OPEN_TRAVEL, c.open_travel, 16);
    put_reg(CFG_CLOSE_TRAVEL, c.close_travel, 16);
    cfg_we <= 1'b0;
    regs_now = c;
  endtask

  function automatic in_word_t noise_tick(input logic [3:0] sw);
    in_word_t w;
    int v;
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) v = 0;
    else if (pick == 1) v = 1023;
    else if (pick < 5) v = int'(regs_now.light_limit) + int'($urandom_range(2)) - 1;
    else v = $urandom_range(1023);
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    w.light_level = 10'(v);
    w.switches = sw;
    w.minute_pulse = $urandom_range(99) < 60;
    return w;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : result_check
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (status_due.size() == 0) begin
        $display("%0t: unexpected word expected none got %h", $time, out_data);
        mismatches++;
      end else begin
        want = status_due.pop_front();
        check_field("coil_pattern", 16'(want.coil_pattern), 16'(out_data.coil_pattern));
        check_field("blind_is_open", 16'(want.blind_is_open), 16'(out_data.blind_is_open));
        check_field("moving", 16'(want.moving), 16'(out_data.moving));
        check_field("mode", 16'(want.mode), 16'(out_data.mode));
        check_field("hour", 16'(want.hour), 16'(out_data.hour));
        check_field("minute", 16'(want.minute), 16'(out_data.minute));
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= $urandom_range(99) >= take_stall_pct;
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
    $display("FAIL blind_stepper_controller");
    $finish;
  end

  initial begin : stimulus
    cfg_regs_t c;
    in_word_t w;
    mode_t favored;
    int t_open;
    int t_close;
    int pick;
    int mi;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;

    regs_now.light_limit = RST_LIGHT_LIMIT;
    regs_now.open_hr = RST_OPEN_HR;
    regs_now.open_minute = RST_OPEN_MINUTE;
    regs_now.close_hr = RST_CLOSE_HR;
    regs_now.close_minute = RST_CLOSE_MINUTE;
    regs_now.open_travel = RST_OPEN_TRAVEL;
    regs_now.close_travel = RST_CLOSE_TRAVEL;
    blind_open = 1'b0;
    cur_mode = MODE_PICK;
    mode_held = 1'b0;
    coil_phase = 3'd0;
    steps_to_go = 16'd0;
    move_up = 1'b0;
    coil_bits = 4'd0;
    clk_hour = RST_HOUR;
    clk_minute = RST_MINUTE;

    // reset settings: no row may start a move
    opening_rows[0] = {10'd0, 4'hF, 1'b0, 1'b1, 4'h0, 1'b0, 1'b0, MODE_PICK, 5'd7, 6'd0};
    opening_rows[1] = {10'd1023, 4'b0111, 1'b1, 1'b1, 4'h0, 1'b0, 1'b0, MODE_PICK, 5'd7, 6'd1};
    // latched: pressing everything changes nothing
    opening_rows[2] = {10'd1023, 4'b0000, 1'b1, 1'b1, 4'h0, 1'b0, 1'b0, MODE_PICK, 5'd7, 6'd2};
    opening_rows[3] = {10'd0, 4'hF, 1'b0, 1'b1, 4'h0, 1'b0, 1'b0, MODE_PICK, 5'd7, 6'd2};
    opening_rows[4] = {10'd1023, 4'b1011, 1'b1, 1'b1, 4'h0, 1'b0, 1'b0, MODE_MANUAL, 5'd7, 6'd3};
    opening_rows[5] = {10'd0, 4'hF, 1'b0, 1'b1, 4'h0, 1'b0, 1'b0, MODE_MANUAL, 5'd7, 6'd3};
    opening_rows[6] = {10'd0, 4'b0000, 1'b1, 1'b1, 4'h0, 1'b0, 1'b0, MODE_LIGHT, 5'd7, 6'd4};
    // level equal to threshold is not above it
    opening_rows[7] = {10'd400, 4'b1110, 1'b1, 1'b1, 4'h0, 1'b0, 1'b0, MODE_LIGHT, 5'd7, 6'd5};
    // tuned settings: short open travel, zero close travel, unmatchable close time
    opening_rows[8] = {10'd1, 4'b1110, 1'b1, 1'b0, 19'd0};
    opening_rows[9] = {10'd0, 4'b1110, 1'b1, 1'b0, 19'd0};
    opening_rows[10] = {10'd0, 4'hF, 1'b0, 1'b0, 19'd0};
    opening_rows[11] = {10'd0, 4'b1101, 1'b1, 1'b0, 19'd0};
    opening_rows[12] = {10'd0, 4'hF, 1'b0, 1'b0, 19'd0};
    opening_rows[13] = {10'd0, 4'b1010, 1'b1, 1'b0, 19'd0};
    opening_rows[14] = {10'd1023, 4'hF, 1'b1, 1'b0, 19'd0};
    opening_rows[15] = {10'd512, 4'b0111, 1'b0, 1'b0, 19'd0};
    opening_rows[16] = {10'd512, 4'hF, 1'b1, 1'b0, 19'd0};
    opening_rows[17] = {10'd1023, 4'b1110, 1'b1, 1'b0, 19'd0};

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < OPENING_ROWS; i++) begin
      if (i == TUNED_FROM) begin
        wait_drained();
        c.light_limit = 10'd0;
        c.open_hr = 5'd7;
        c.open_minute = 6'd7;
        c.close_hr = 5'd31;
        c.close_minute = 6'd63;
        c.open_travel = 16'd3;
        c.close_travel = 16'd0;
        load_config(c);
      end
      send_word(opening_rows[i].w, opening_rows[i].typed, opening_rows[i].want);
    end

    for (int k = 0; k < SEGMENTS; k++) begin
      wait_drained();
      case (k / 5)
        0: begin send_gap_pct = 0; take_stall_pct = 0; end
        1: begin send_gap_pct = 86; take_stall_pct = 0; end
        2: begin send_gap_pct = 0; take_stall_pct = 86; end
        default: begin send_gap_pct = 14; take_stall_pct = 14; end
      endcase

      pick = $urandom_range(9);
      if (pick == 0) c.light_limit = 10'd0;
      else if (pick == 1) c.light_limit = 10'd1023;
      else c.light_limit = 10'($urandom);
      // put the schedule a few minutes ahead of the running clock
      t_open = int'(clk_hour) * 60 + int'(clk_minute) + int'($urandom_range(6));
      t_close = t_open + int'($urandom_range(10));
      c.open_hr = 5'((t_open / 60) % 24);
      c.open_minute = 6'(t_open % 60);
      c.close_hr = 5'((t_close / 60) % 24);
      c.close_minute = 6'(t_close % 60);
      if ($urandom_range(7) == 0) c.open_hr = 5'(24 + $urandom_range(7));
      if ($urandom_range(7) == 0) c.open_minute = 6'(60 + $urandom_range(3));
      if ($urandom_range(7) == 0) c.close_hr = 5'(24 + $urandom_range(7));
      if ($urandom_range(7) == 0) c.close_minute = 6'(60 + $urandom_range(3));
      pick = $urandom_range(9);
      if (pick == 0) c.open_travel = 16'd0;
      else if (pick == 1) c.open_travel = 16'd1;
      else if (pick == 2) c.open_travel = 16'($urandom_range(300, 100));
      else c.open_travel = 16'($urandom_range(12, 2));
      pick = $urandom_range(9);
      if (pick == 0) c.close_travel = 16'd0;
      else if (pick == 1) c.close_travel = 16'd1;
      else if (pick == 2) c.close_travel = 16'($urandom_range(300, 100));
      else c.close_travel = 16'($urandom_range(12, 2));
      if (k == 0) c.light_limit = 10'd1023;
      if (k == SEGMENTS - 1) begin
        c.light_limit = 10'd0;
        c.open_travel = 16'hFFFF;
        c.close_travel = 16'hFFFF;
      end
      load_config(c);

      pick = $urandom_range(9);
      if (pick < 4) favored = MODE_SCHED;
      else if (pick < 8) favored = MODE_LIGHT;
      else if (pick == 8) favored = MODE_MANUAL;
      else favored = MODE_PICK;
      if (k == SEGMENTS - 1) favored = MODE_LIGHT;
      mi = int'(favored);

      // release, then press the chosen switch with lower ones released
      send_word(noise_tick(SW_ALL_RELEASED), 1'b0, '0);
      send_word(noise_tick((4'($urandom) & ~(4'd1 << mi)) | 4'((1 << mi) - 1)), 1'b0, '0);
      for (int n = 2; n < SEGMENT_TICKS; n++) begin
        w = noise_tick(($urandom_range(99) < 92) ? SW_ALL_RELEASED : 4'($urandom));
        send_word(w, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    send_gap_pct = 0;
    take_stall_pct = 0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS blind_stepper_controller");
    end else begin
      $display("FAIL blind_stepper_controller");
    end
    $finish;
  end

endmodule
